[rtl/core/mlpq_pkg.sv]
// Package for the strict-priority multi-level FIFO.
// Holds sizes, command and status codes, the sequencer states and the
// structs passed between the pointer block and the top level.
`timescale 1ns / 1ps

package mlpq_pkg;

	// Sizes
	localparam int LEVELS = 4;
	localparam int DEPTH  = 16;
	localparam int DATA_W = 32;
	localparam int CMD_W  = 2;
	localparam int PRIO_W = 2;
	localparam int STAT_W = 2;
	localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int ADDR_W = LVL_W + IDX_W;

	// Stream payload widths, padded to whole bytes
	localparam int IN_BITS  = CMD_W + DATA_W + PRIO_W;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = STAT_W + DATA_W + DATA_W + 1;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_ENQ = 2'd0,
		CMD_DEQ = 2'd1,
		CMD_QRY = 2'd2
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE  = 2'd0,
		ST_DROP  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_READ,
		FSM_LOAD
	} fsm_t;

	// Request to the pointer block
	typedef struct packed {
		logic              valid;
		cmd_t              cmd;
		logic [PRIO_W-1:0] prio;
	} ptr_op_t;

	// Outcome of a request: store write and status
	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		status_t           status;
	} ptr_res_t;

	// Front/rear location of the current queue state
	typedef struct packed {
		logic              all_empty;
		logic [ADDR_W-1:0] front_addr;
		logic [ADDR_W-1:0] rear_addr;
	} ptr_view_t;

endpackage

[rtl/core/mlpq_ram.sv]
// Generic synchronous RAM: one write port, two read ports.
// Read data is registered. No dependencies.
`timescale 1ns / 1ps

module mlpq_ram #(
	parameter int AW = 6,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr_a,
	input  logic [AW-1:0] raddr_b,
	output logic [DW-1:0] rdata_a,
	output logic [DW-1:0] rdata_b
);

	logic [DW-1:0] mem_q [2**AW];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read ports, hold data when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

[rtl/core/mlpq_ptr.sv]
// Head, tail and fill count per priority level, plus level scan.
// Depends on mlpq_pkg.
`timescale 1ns / 1ps

module mlpq_ptr (
	input  logic                clk,
	input  logic                arst_n,
	input  mlpq_pkg::ptr_op_t   op,
	output mlpq_pkg::ptr_res_t  res,
	output mlpq_pkg::ptr_view_t view
);

	import mlpq_pkg::*;

	logic [IDX_W-1:0] head_q [LEVELS];
	logic [IDX_W-1:0] tail_q [LEVELS];
	logic [CNT_W-1:0] cnt_q  [LEVELS];

	logic             hi_found;
	logic [LVL_W-1:0] hi_lvl;
	logic [LVL_W-1:0] lo_lvl;
	logic [LVL_W-1:0] req_lvl;
	logic             lvl_ok;
	logic             enq_ok;
	logic             deq_ok;
	logic [IDX_W-1:0] tail_next;
	logic [IDX_W-1:0] head_next;

	function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx);
		logic [IDX_W-1:0] r;
		if (idx == IDX_W'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = idx + IDX_W'(1);
		end
		return r;
	endfunction

	// Scan levels: highest and lowest non-empty
	always_comb begin
		hi_found = 1'b0;
		hi_lvl   = '0;
		lo_lvl   = '0;
		for (int l = 0; l < LEVELS; l++) begin
			if (cnt_q[l] != '0) begin
				hi_lvl   = LVL_W'(l);
				hi_found = 1'b1;
			end
		end
		for (int l = LEVELS - 1; l >= 0; l--) begin
			if (cnt_q[l] != '0) begin
				lo_lvl = LVL_W'(l);
			end
		end
	end

	// Decode the request
	always_comb begin
		req_lvl   = LVL_W'(op.prio);
		lvl_ok    = (int'(op.prio) < LEVELS);
		tail_next = wrap_inc(tail_q[req_lvl]);
		head_next = wrap_inc(head_q[hi_lvl]);
		enq_ok    = 1'b0;
		deq_ok    = 1'b0;
		res.status = ST_DONE;
		case (op.cmd)
			CMD_ENQ: begin
				if (lvl_ok && (cnt_q[req_lvl] < CNT_W'(DEPTH))) begin
					enq_ok = op.valid;
				end else begin
					res.status = ST_DROP;
				end
			end
			CMD_DEQ: begin
				if (hi_found) begin
					deq_ok = op.valid;
				end else begin
					res.status = ST_EMPTY;
				end
			end
			default: begin
				res.status = ST_DONE;
			end
		endcase
		res.wr_en   = enq_ok;
		res.wr_addr = {req_lvl, tail_next};
	end

	// Advance pointers and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < LEVELS; l++) begin
				head_q[l] <= '0;
				tail_q[l] <= IDX_W'(DEPTH - 1);
				cnt_q[l]  <= '0;
			end
		end else if (enq_ok) begin
			tail_q[req_lvl] <= tail_next;
			cnt_q[req_lvl]  <= cnt_q[req_lvl] + CNT_W'(1);
		end else if (deq_ok) begin
			head_q[hi_lvl] <= head_next;
			cnt_q[hi_lvl]  <= cnt_q[hi_lvl] - CNT_W'(1);
		end
	end

	// Front and rear locations of the current state
	assign view.all_empty  = !hi_found;
	assign view.front_addr = {hi_lvl, head_q[hi_lvl]};
	assign view.rear_addr  = {lo_lvl, tail_q[lo_lvl]};

endmodule

[rtl/core/multi_level_priority_fifo_unit.sv]
// Strict-priority multi-level FIFO, top level. Uses mlpq_pkg, mlpq_ptr, mlpq_ram.
// Sequence: pointer update at accept, entry store read, then output load,
// which waits while the output holds an untaken result. A new item is
// not accepted until the previous one has been loaded into the output.
// Reset: arst_n clears pointers, counts, sequencer and output valid; the
// entry store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module multi_level_priority_fifo_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// command[1:0], item_value[33:2], priority_req[35:34], zero pad
	input  logic [mlpq_pkg::IN_W-1:0]  s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// status[1:0], front_value[33:2], rear_value[65:34], all_empty[66], zero pad
	output logic [mlpq_pkg::OUT_W-1:0] m_tdata
);

	import mlpq_pkg::*;

	localparam int VAL_LO  = CMD_W;
	localparam int PRIO_LO = CMD_W + DATA_W;

	fsm_t      state_q, state_d;
	ptr_op_t   op;
	ptr_res_t  res;
	ptr_view_t view;

	logic               in_acc;
	logic               rd_en;
	logic               load;
	logic [DATA_W-1:0]  rd_front;
	logic [DATA_W-1:0]  rd_rear;
	status_t            status_q;
	logic               empty_q;
	logic               out_valid_q;
	logic [OUT_BITS-1:0] out_q;

	assign in_acc = s_tvalid && s_tready;

	// Request to pointer block
	assign op.valid = in_acc;
	assign op.cmd   = cmd_t'(s_tdata[CMD_W-1:0]);
	assign op.prio  = s_tdata[PRIO_LO +: PRIO_W];

	mlpq_ptr u_ptr (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.res    (res),
		.view   (view)
	);

	mlpq_ram #(
		.AW (ADDR_W),
		.DW (DATA_W)
	) u_ram (
		.clk     (clk),
		.we      (res.wr_en),
		.waddr   (res.wr_addr),
		.wdata   (s_tdata[VAL_LO +: DATA_W]),
		.re      (rd_en),
		.raddr_a (view.front_addr),
		.raddr_b (view.rear_addr),
		.rdata_a (rd_front),
		.rdata_b (rd_rear)
	);

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and strobes
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		rd_en    = 1'b0;
		load     = 1'b0;
		unique case (state_q)
			FSM_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = FSM_READ;
				end
			end
			FSM_READ: begin
				rd_en   = 1'b1;
				state_d = FSM_LOAD;
			end
			FSM_LOAD: begin
				if (!out_valid_q || m_tready) begin
					load    = 1'b1;
					state_d = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	// Capture status at accept and empty flag at read
	always_ff @(posedge clk) begin
		if (in_acc) begin
			status_q <= res.status;
		end
		if (rd_en) begin
			empty_q <= view.all_empty;
		end
	end

	// Output register: load result, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= {empty_q,
			          empty_q ? {DATA_W{1'b0}} : rd_rear,
			          empty_q ? {DATA_W{1'b0}} : rd_front,
			          status_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_W - OUT_BITS){1'b0}}, out_q};

endmodule
